@@ rtl/bsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and constants of the bitmap slot allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

	localparam int SLOT_W        = 12;
	localparam int CFG_W         = 13;
	localparam int CFG_IDX_W     = 1;
	localparam int STATUS_W      = 2;

	localparam int MAX_SLOTS_DEF = 4096;
	localparam int WORD_BITS_DEF = 64;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_TOTAL    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 1'd1;

	localparam logic [CFG_W-1:0] TOTAL_RESET    = 13'd4096;
	localparam logic [CFG_W-1:0] RESERVED_RESET = 13'd1;

	typedef struct packed {
		logic              func;
		logic [SLOT_W-1:0] slot_index;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   granted_slot;
	} rsp_t;

endpackage

@@ rtl/bitmap_slot_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_slot_allocator
// Slot allocator over a used-bit map held in RAM, with a per-word full summary.
// ----------------------------------------------------------------------------
// One request at a time. An allocate reads the first in-range word and, if it
// has no free slot, moves the search to the next non-full word; a free reads
// and rewrites one word; a rejected request reads nothing. Each request first
// passes the two-stage word/bit split of the slot bounds, and the RAM read is
// registered before each read-modify-write. After reset the map RAM is cleared
// one word per cycle while req_stall stays high; configuration writes are
// taken throughout. A finished response waits in an output register, so the
// next request is accepted while rsp is stalled.
module bitmap_slot_allocator
	import bsa_pkg::*;
#(
	parameter int MAX_SLOTS = MAX_SLOTS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int SW    = $clog2(MAX_SLOTS + 1);
	localparam int XW    = (SW > CFG_W) ? SW : CFG_W;
	localparam int WORDS = (MAX_SLOTS + WORD_BITS - 1) / WORD_BITS;
	localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int BW    = $clog2(WORD_BITS);

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_S1   = 4'd2;
	localparam logic [3:0] S_S2   = 4'd3;
	localparam logic [3:0] S_S3   = 4'd4;
	localparam logic [3:0] S_FRD  = 4'd5;
	localparam logic [3:0] S_A1   = 4'd6;
	localparam logic [3:0] S_A2   = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;

	function automatic logic [XW-1:0] clamp(input logic [CFG_W-1:0] v);
		logic [XW-1:0] ext;
		ext = XW'(v);
		return (ext > XW'(MAX_SLOTS)) ? XW'(MAX_SLOTS) : ext;
	endfunction

	logic [3:0]           state_q;
	logic [WW-1:0]        clr_q;
	logic [CFG_W-1:0]     total_q;
	logic [CFG_W-1:0]     reserved_q;
	logic [WORDS-1:0]     full_q;
	logic                 rsp_valid_q;

	logic                 func_q;
	logic [XW-1:0]        idx_q;
	logic [XW-1:0]        lo_q;
	logic [XW-1:0]        hi_q;
	logic [WW-1:0]        cur_w_q;
	rsp_t                 res_q;
	rsp_t                 rsp_q;

	logic [WW-1:0]        a_w;
	logic [BW-1:0]        a_b;
	logic [WW-1:0]        b_w;
	logic [BW-1:0]        b_b;

	logic                 empty;
	logic                 bad;
	logic                 accept;
	logic                 load_rsp;

	logic                 ram_we;
	logic [WW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [WW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] rd_data;

	logic [WW-1:0]        srch_w;
	logic [WORD_BITS-1:0] bit_mask;
	logic [WORD_BITS-1:0] free_v;
	logic [WORD_BITS-1:0] low_oh;
	logic                 hit;
	logic [BW-1:0]        bit_p;
	logic [WORD_BITS-1:0] set_word;
	logic [WORD_BITS-1:0] clr_word;

	logic [WORDS-1:0]     cand;
	logic [WORDS-1:0]     cand_oh;
	logic                 next_hit;
	logic [WW-1:0]        next_w;
	logic [SW-1:0]        grant;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign load_rsp  = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	bsa_split #(
		.SW(SW), .WORD_BITS(WORD_BITS), .WW(WW), .BW(BW)
	) u_split_a (
		.clk(clk),
		.x(SW'((func_q == FUNC_FREE) ? idx_q : lo_q)),
		.word(a_w),
		.bit_ofs(a_b)
	);

	bsa_split #(
		.SW(SW), .WORD_BITS(WORD_BITS), .WW(WW), .BW(BW)
	) u_split_b (
		.clk(clk),
		.x(SW'(hi_q - XW'(1))),
		.word(b_w),
		.bit_ofs(b_b)
	);

	bsa_ram #(
		.WIDTH(WORD_BITS), .DEPTH(WORDS)
	) u_map (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(rd_data)
	);

	assign empty = (lo_q >= hi_q);
	assign bad   = (idx_q < lo_q) || (idx_q >= hi_q);

	// free bits of the word just read, limited to the slot range
	assign srch_w = (state_q == S_A1) ? a_w : cur_w_q;

	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			bit_mask[i] = ((state_q != S_A1) || (BW'(i) >= a_b)) &&
			              ((srch_w != b_w) || (BW'(i) <= b_b));
		end
	end

	assign free_v   = ~rd_data & bit_mask;
	assign low_oh   = free_v & (~free_v + WORD_BITS'(1));
	assign hit      = |free_v;
	assign set_word = rd_data | low_oh;
	assign clr_word = rd_data & ~(WORD_BITS'(1) << a_b);

	always_comb begin
		bit_p = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (low_oh[i]) begin
				bit_p = bit_p | BW'(i);
			end
		end
	end

	// next word above the first one that still has a free slot
	always_comb begin
		for (int j = 0; j < WORDS; j++) begin
			cand[j] = !full_q[j] && (WW'(j) > a_w) && (WW'(j) <= b_w);
		end
	end

	assign cand_oh  = cand & (~cand + WORDS'(1));
	assign next_hit = |cand;

	always_comb begin
		next_w = '0;
		for (int j = 0; j < WORDS; j++) begin
			if (cand_oh[j]) begin
				next_w = next_w | WW'(j);
			end
		end
	end

	assign grant = SW'(srch_w) * SW'(WORD_BITS) + SW'(bit_p);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = a_w;
		ram_wdata = set_word;
		ram_re    = 1'b0;
		ram_raddr = a_w;
		unique case (state_q)
			S_CLR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_S3: begin
				ram_re = (func_q == FUNC_FREE) ? !bad : !empty;
			end
			S_FRD: begin
				ram_we    = 1'b1;
				ram_wdata = clr_word;
			end
			S_A1: begin
				if (hit) begin
					ram_we = 1'b1;
				end else begin
					ram_re    = next_hit;
					ram_raddr = next_w;
				end
			end
			S_A2: begin
				ram_we    = hit;
				ram_waddr = cur_w_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			total_q     <= TOTAL_RESET;
			reserved_q  <= RESERVED_RESET;
			full_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TOTAL:    total_q    <= cfg_data;
					REG_RESERVED: reserved_q <= cfg_data;
				endcase
			end

			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + WW'(1);
					if (clr_q == WW'(WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_S1;
					end
				end
				S_S1: state_q <= S_S2;
				S_S2: state_q <= S_S3;
				S_S3: begin
					if (func_q == FUNC_FREE) begin
						state_q <= bad ? S_DONE : S_FRD;
					end else begin
						state_q <= empty ? S_DONE : S_A1;
					end
				end
				S_FRD: begin
					full_q[a_w] <= 1'b0;
					state_q     <= S_DONE;
				end
				S_A1: begin
					if (hit) begin
						full_q[a_w] <= &set_word;
						state_q     <= S_DONE;
					end else if (next_hit) begin
						state_q <= S_A2;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_A2: begin
					if (hit) begin
						full_q[cur_w_q] <= &set_word;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_rsp) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= req.func;
			idx_q  <= XW'(req.slot_index);
			lo_q   <= clamp(reserved_q);
			hi_q   <= clamp(total_q);
		end

		case (state_q)
			S_S3: begin
				if (func_q == FUNC_FREE) begin
					res_q <= '{status: (bad ? ST_BAD : ST_OK), granted_slot: '0};
				end else begin
					res_q <= '{status: ST_FULL, granted_slot: '0};
				end
			end
			S_FRD: res_q <= '{status: ST_OK, granted_slot: '0};
			S_A1: begin
				cur_w_q <= next_w;
				if (hit) begin
					res_q <= '{status: ST_OK, granted_slot: SLOT_W'(grant)};
				end else begin
					res_q <= '{status: ST_FULL, granted_slot: '0};
				end
			end
			S_A2: begin
				if (hit) begin
					res_q <= '{status: ST_OK, granted_slot: SLOT_W'(grant)};
				end else begin
					res_q <= '{status: ST_FULL, granted_slot: '0};
				end
			end
			default: begin
			end
		endcase

		if (load_rsp) begin
			rsp_q <= res_q;
		end
	end

endmodule

@@ rtl/bsa_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bsa_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/bsa_split.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_split
// Two-stage unit that splits a slot number into map word and bit offset,
// using a reciprocal multiply for the word and a back-multiply for the bit.
// ----------------------------------------------------------------------------
module bsa_split #(
	parameter int SW        = 13,
	parameter int WORD_BITS = 64,
	parameter int WW        = 6,
	parameter int BW        = 6
) (
	input  logic          clk,
	input  logic [SW-1:0] x,
	output logic [WW-1:0] word,
	output logic [BW-1:0] bit_ofs
);

	localparam int SH = SW + BW;
	localparam int MW = SW + 1;
	localparam int PW = SW + MW;
	localparam logic [MW-1:0] RECIP = MW'(((1 << SH) + WORD_BITS - 1) / WORD_BITS);
	localparam logic [SW-1:0] WB_C  = SW'(WORD_BITS);

	logic [PW-1:0] prod;
	logic [SW-1:0] q_s1;
	logic [SW-1:0] x_s1;
	logic [SW-1:0] rem;

	assign prod = PW'(x) * PW'(RECIP);

	always_ff @(posedge clk) begin
		q_s1 <= SW'(prod >> SH);
		x_s1 <= x;
	end

	assign rem = x_s1 - q_s1 * WB_C;

	always_ff @(posedge clk) begin
		word    <= WW'(q_s1);
		bit_ofs <= BW'(rem);
	end

endmodule

@@ rtl/bsa_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsa_checker
// Port-level checks of the bitmap slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bsa_checker
	import bsa_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_stall,
	input req_t                 req,
	input logic                 rsp_valid,
	input logic                 rsp_stall,
	input rsp_t                 rsp,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_W-1:0]     cfg_data
);

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// one request at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while busy");

	// failed requests grant nothing
	a_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |-> (rsp.granted_slot == '0))
		else $error("grant on failed request");

	// a response appears only out of a busy cycle
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response without work");

endmodule

bind bitmap_slot_allocator bsa_checker u_bsa_checker (.*);
